FILE: rtl/buddy_page_allocator_assert.svh
// assertion macros shared by the buddy allocator rtl
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked property, off while reset is high
`define BPA_ASSERT(lbl, clk_e, rst_e, prop, msg) \
  lbl: assert property (@(posedge clk_e) disable iff (rst_e) prop) else $error(msg);
// checked property, also during reset
`define BPA_ASSERT_ALWAYS(lbl, clk_e, prop, msg) \
  lbl: assert property (@(posedge clk_e) prop) else $error(msg);
`else
`define BPA_ASSERT(lbl, clk_e, rst_e, prop, msg)
`define BPA_ASSERT_ALWAYS(lbl, clk_e, prop, msg)
`endif
`endif

FILE: rtl/bpa_pkg.sv
// shared types and constants of the buddy page allocator
`default_nettype none
package bpa_pkg;
  localparam int MAX_ORDER = 4;
  localparam int FRAMES    = 4096;
  localparam int FRAME_W   = $clog2(FRAMES);
  localparam int LINK_W    = FRAME_W + 1;
  localparam int ORDER_W   = 3;
  localparam int FORDER_W  = 4;
  localparam int COUNT_W   = 16;
  localparam int REG_W     = 13;
  localparam int SPAN_W    = REG_W + 1;
  localparam int BLK       = 1 << MAX_ORDER;
  localparam int HEADS     = MAX_ORDER + 1;

  localparam logic [LINK_W-1:0]   NIL         = LINK_W'(FRAMES);
  localparam logic [FORDER_W-1:0] MERGED_AWAY = 4'd15;

  typedef enum logic [1:0] {CMD_ALLOC, CMD_FREE, CMD_INIT, CMD_NOP} cmd_t;
  typedef enum logic [1:0] {FS_RESERVED, FS_FREE, FS_ALLOC} fstate_t;
  typedef enum logic {REG_REGION_START, REG_REGION_END} reg_idx_t;

  typedef struct packed {
    logic [FORDER_W-1:0] order;
    fstate_t             st;
  } finfo_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LATCH, OP_SWEEP, OP_A_FIND, OP_A_UNLINK, OP_A_SPLIT,
    OP_F_CHECK, OP_F_STATE, OP_F_PAIR, OP_F_PCHK, OP_F_UNLINK,
    OP_PUSH1, OP_PUSH2, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SWEEP, ST_A_FIND, ST_A_UNLINK, ST_A_SPLIT,
    ST_F_CHECK, ST_F_STATE, ST_F_PAIR, ST_F_PCHK, ST_F_UNLINK,
    ST_PUSH1, ST_PUSH2, ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic ok;
  } dp_cmd_t;

  typedef struct packed {
    logic fail;
    logic stop;
    logic sweep_last;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    cmd_t                 command;
    logic [COUNT_W-1:0]   page_count;
    logic [FRAME_W-1:0]   block_pfn;
    logic [ORDER_W-1:0]   block_order;
  } req_t;
endpackage
`default_nettype wire

FILE: rtl/bpa_if.sv
// request and response channel interfaces
`default_nettype none
interface bpa_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [bpa_pkg::COUNT_W-1:0]   page_count;
  logic [bpa_pkg::FRAME_W-1:0]   block_pfn;
  logic [bpa_pkg::ORDER_W-1:0]   block_order;
  modport source (output valid, command, page_count, block_pfn, block_order, input ready);
  modport sink (input valid, command, page_count, block_pfn, block_order, output ready);
endinterface

interface bpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [bpa_pkg::FRAME_W-1:0]   result_pfn;
  logic [bpa_pkg::ORDER_W-1:0]   result_order;
  modport source (output valid, ok, result_pfn, result_order, input ready);
  modport sink (input valid, ok, result_pfn, result_order, output ready);
endinterface
`default_nettype wire

FILE: rtl/bpa_ctrl.sv
// sequencer state machine of the buddy allocator
`default_nettype none
`include "buddy_page_allocator_assert.svh"
module bpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_command,
  output logic                req_ready,
  input  bpa_pkg::dp_status_t status,
  output bpa_pkg::dp_cmd_t    cmd
);
  bpa_pkg::state_t state, state_next;
  logic ok_flag, ok_flag_next;
  logic is_alloc, is_alloc_next;
  logic report, report_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bpa_pkg::ST_SWEEP;
      ok_flag  <= 1'b0;
      is_alloc <= 1'b0;
      report   <= 1'b0;
    end else begin
      state    <= state_next;
      ok_flag  <= ok_flag_next;
      is_alloc <= is_alloc_next;
      report   <= report_next;
    end
  end

  always_comb begin
    state_next    = state;
    ok_flag_next  = ok_flag;
    is_alloc_next = is_alloc;
    report_next   = report;
    req_ready     = 1'b0;
    cmd.op        = bpa_pkg::OP_IDLE;
    cmd.ok        = ok_flag;
    case (state)
      bpa_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op = bpa_pkg::OP_LATCH;
          case (bpa_pkg::cmd_t'(req_command))
            bpa_pkg::CMD_ALLOC: begin
              is_alloc_next = 1'b1;
              state_next    = bpa_pkg::ST_A_FIND;
            end
            bpa_pkg::CMD_FREE: begin
              is_alloc_next = 1'b0;
              state_next    = bpa_pkg::ST_F_CHECK;
            end
            bpa_pkg::CMD_INIT: begin
              report_next = 1'b1;
              state_next  = bpa_pkg::ST_SWEEP;
            end
            default: begin
              ok_flag_next = 1'b0;
              state_next   = bpa_pkg::ST_DONE;
            end
          endcase
        end
      end
      bpa_pkg::ST_SWEEP: begin
        cmd.op = bpa_pkg::OP_SWEEP;
        if (status.sweep_last) begin
          ok_flag_next = 1'b1;
          report_next  = 1'b0;
          state_next   = report ? bpa_pkg::ST_DONE : bpa_pkg::ST_IDLE;
        end
      end
      bpa_pkg::ST_A_FIND: begin
        cmd.op = bpa_pkg::OP_A_FIND;
        if (status.fail) begin
          ok_flag_next = 1'b0;
          state_next   = bpa_pkg::ST_DONE;
        end else begin
          state_next = bpa_pkg::ST_A_UNLINK;
        end
      end
      bpa_pkg::ST_A_UNLINK: begin
        cmd.op     = bpa_pkg::OP_A_UNLINK;
        state_next = bpa_pkg::ST_A_SPLIT;
      end
      bpa_pkg::ST_A_SPLIT: begin
        cmd.op = bpa_pkg::OP_A_SPLIT;
        if (status.stop) begin
          ok_flag_next = 1'b1;
          state_next   = bpa_pkg::ST_DONE;
        end else begin
          state_next = bpa_pkg::ST_PUSH1;
        end
      end
      bpa_pkg::ST_F_CHECK: begin
        cmd.op = bpa_pkg::OP_F_CHECK;
        if (status.fail) begin
          ok_flag_next = 1'b0;
          state_next   = bpa_pkg::ST_DONE;
        end else begin
          state_next = bpa_pkg::ST_F_STATE;
        end
      end
      bpa_pkg::ST_F_STATE: begin
        cmd.op = bpa_pkg::OP_F_STATE;
        if (status.fail) begin
          ok_flag_next = 1'b0;
          state_next   = bpa_pkg::ST_DONE;
        end else begin
          state_next = bpa_pkg::ST_F_PAIR;
        end
      end
      bpa_pkg::ST_F_PAIR: begin
        cmd.op     = bpa_pkg::OP_F_PAIR;
        state_next = status.stop ? bpa_pkg::ST_PUSH1 : bpa_pkg::ST_F_PCHK;
      end
      bpa_pkg::ST_F_PCHK: begin
        cmd.op     = bpa_pkg::OP_F_PCHK;
        state_next = status.stop ? bpa_pkg::ST_PUSH1 : bpa_pkg::ST_F_UNLINK;
      end
      bpa_pkg::ST_F_UNLINK: begin
        cmd.op     = bpa_pkg::OP_F_UNLINK;
        state_next = bpa_pkg::ST_F_PAIR;
      end
      bpa_pkg::ST_PUSH1: begin
        cmd.op     = bpa_pkg::OP_PUSH1;
        state_next = bpa_pkg::ST_PUSH2;
      end
      bpa_pkg::ST_PUSH2: begin
        cmd.op = bpa_pkg::OP_PUSH2;
        if (is_alloc) begin
          state_next = bpa_pkg::ST_A_SPLIT;
        end else begin
          ok_flag_next = 1'b1;
          state_next   = bpa_pkg::ST_DONE;
        end
      end
      bpa_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.op     = bpa_pkg::OP_OUT;
          state_next = bpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  `BPA_ASSERT(a_sweep_hold, clk, rst, (state == bpa_pkg::ST_SWEEP && !status.sweep_last) |=> (state == bpa_pkg::ST_SWEEP), "sweep ended early")
  `BPA_ASSERT(a_out_free, clk, rst, (cmd.op == bpa_pkg::OP_OUT) |-> !status.out_busy, "result beat overwritten")
  `BPA_ASSERT(a_accept_busy, clk, rst, (req_valid && req_ready) |=> (state != bpa_pkg::ST_IDLE), "accepted beat not started")
  `BPA_ASSERT_ALWAYS(a_reset_sweep, clk, rst |=> (state == bpa_pkg::ST_SWEEP), "no clearing sweep after reset")
endmodule
`default_nettype wire

FILE: rtl/bpa_datapath.sv
// frame memories, free list heads and working registers
`default_nettype none
module bpa_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  bpa_pkg::dp_cmd_t                cmd,
  output bpa_pkg::dp_status_t             status,
  input  bpa_pkg::req_t                   req,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [bpa_pkg::REG_W-1:0]       cfg_data,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic                            rsp_ok,
  output logic [bpa_pkg::FRAME_W-1:0]     rsp_pfn,
  output logic [bpa_pkg::ORDER_W-1:0]     rsp_order
);
  localparam int FW = bpa_pkg::FRAME_W;
  localparam int LW = bpa_pkg::LINK_W;
  localparam int OW = bpa_pkg::ORDER_W;
  localparam int SW = bpa_pkg::SPAN_W;
  localparam int RW = bpa_pkg::REG_W;

  bpa_pkg::finfo_t info_mem [bpa_pkg::FRAMES];
  logic [LW-1:0]   next_mem [bpa_pkg::FRAMES];
  logic [LW-1:0]   prev_mem [bpa_pkg::FRAMES];

  logic [RW-1:0] region_start, region_end;
  logic [SW-1:0] span_s;
  logic [RW-1:0] span_e;
  logic [LW-1:0] list_head [bpa_pkg::HEADS];
  logic [FW-1:0] sweep_idx, pfn, pf, pair, rel;
  logic [OW-1:0] cur, want;
  logic          alloc_bad;
  logic [LW-1:0] h;
  bpa_pkg::finfo_t info_rd;
  logic [LW-1:0] next_rd, prev_rd;

  // memory ports
  logic            info_we, next_we, prev_we;
  logic [FW-1:0]   info_wa, next_wa, prev_wa, info_ra, link_ra;
  bpa_pkg::finfo_t info_wd;
  logic [LW-1:0]   next_wd, prev_wd;

  // helpers
  logic [SW-1:0] s_calc;
  logic [RW-1:0] e_clip, e_calc;
  logic [OW-1:0] want_c, a_c;
  logic          bad_c, a_found, f_bad, f_stop_pair, pchk_stop;
  logic          in_reg, blk_start, sweep_last;
  logic [LW-1:0] a_head;
  logic [SW-1:0] blk_sz, pair_full, merged_pfn;
  logic [FW-1:0] prel, comb_rel;

  always_comb begin
    s_calc = (SW'(region_start) + SW'(bpa_pkg::BLK - 1)) & ~SW'(bpa_pkg::BLK - 1);
    e_clip = (region_end > RW'(bpa_pkg::FRAMES)) ? RW'(bpa_pkg::FRAMES) : region_end;
    e_calc = e_clip & ~RW'(bpa_pkg::BLK - 1);

    // smallest order that holds the page count
    want_c = OW'(bpa_pkg::MAX_ORDER);
    for (int k = bpa_pkg::MAX_ORDER; k >= 0; k--) begin
      if (req.page_count <= bpa_pkg::COUNT_W'(1 << k)) want_c = OW'(k);
    end
    bad_c = (req.page_count == '0) || (req.page_count > bpa_pkg::COUNT_W'(bpa_pkg::BLK));

    // lowest non-empty list at or above the wanted order
    a_found = 1'b0;
    a_c     = want;
    for (int k = bpa_pkg::MAX_ORDER; k >= 0; k--) begin
      if (OW'(k) >= want && list_head[k] != bpa_pkg::NIL) begin
        a_found = 1'b1;
        a_c     = OW'(k);
      end
    end
    a_head = list_head[a_c];

    blk_sz = SW'(1) << cur;
    f_bad  = (cur > OW'(bpa_pkg::MAX_ORDER)) || (SW'(pfn) < span_s) ||
             ((rel & (FW'(blk_sz) - FW'(1))) != '0) ||
             (SW'(pfn) + blk_sz > SW'(span_e));
    prel        = rel ^ (FW'(1) << cur);
    pair_full   = span_s + SW'(prel);
    comb_rel    = rel & prel;
    merged_pfn  = span_s + SW'(comb_rel);
    f_stop_pair = (cur == OW'(bpa_pkg::MAX_ORDER)) || (pair_full >= SW'(bpa_pkg::FRAMES));
    pchk_stop   = (info_rd.order != bpa_pkg::FORDER_W'(cur)) ||
                  (info_rd.st != bpa_pkg::FS_FREE);

    in_reg     = (SW'(sweep_idx) >= span_s) && (SW'(sweep_idx) < SW'(span_e));
    blk_start  = sweep_idx[bpa_pkg::MAX_ORDER-1:0] == '0;
    sweep_last = sweep_idx == FW'(bpa_pkg::FRAMES - 1);
  end

  always_comb begin
    info_we = 1'b0;
    info_wa = pfn;
    info_wd = '{order: '0, st: bpa_pkg::FS_RESERVED};
    next_we = 1'b0;
    next_wa = pf;
    next_wd = bpa_pkg::NIL;
    prev_we = 1'b0;
    prev_wa = pf;
    prev_wd = bpa_pkg::NIL;
    info_ra = pfn;
    link_ra = pair;
    status.fail       = 1'b0;
    status.stop       = 1'b0;
    status.sweep_last = sweep_last;
    status.out_busy   = rsp_valid && !rsp_ready;
    case (cmd.op)
      bpa_pkg::OP_SWEEP: begin
        info_we = 1'b1;
        info_wa = sweep_idx;
        if (in_reg) begin
          info_wd.order = blk_start ? bpa_pkg::FORDER_W'(bpa_pkg::MAX_ORDER)
                                    : bpa_pkg::MERGED_AWAY;
          info_wd.st    = bpa_pkg::FS_FREE;
        end
        next_we = 1'b1;
        next_wa = sweep_idx;
        next_wd = (SW'(sweep_idx) == span_s) ? bpa_pkg::NIL
                                             : LW'(sweep_idx) - LW'(bpa_pkg::BLK);
        prev_we = 1'b1;
        prev_wa = sweep_idx;
        prev_wd = (SW'(sweep_idx) + SW'(bpa_pkg::BLK) < SW'(span_e))
                  ? LW'(sweep_idx) + LW'(bpa_pkg::BLK) : bpa_pkg::NIL;
      end
      bpa_pkg::OP_A_FIND: begin
        link_ra     = a_head[FW-1:0];
        status.fail = alloc_bad || !a_found;
      end
      bpa_pkg::OP_A_UNLINK: begin
        info_we = 1'b1;
        info_wa = pfn;
        info_wd = '{order: bpa_pkg::FORDER_W'(want), st: bpa_pkg::FS_ALLOC};
        if (next_rd != bpa_pkg::NIL) begin
          prev_we = 1'b1;
          prev_wa = next_rd[FW-1:0];
          prev_wd = bpa_pkg::NIL;
        end
      end
      bpa_pkg::OP_A_SPLIT: begin
        status.stop = cur == want;
      end
      bpa_pkg::OP_PUSH1: begin
        info_we = 1'b1;
        info_wa = pf;
        info_wd = '{order: bpa_pkg::FORDER_W'(cur), st: bpa_pkg::FS_FREE};
        next_we = 1'b1;
        next_wa = pf;
        next_wd = list_head[cur];
        prev_we = 1'b1;
        prev_wa = pf;
        prev_wd = bpa_pkg::NIL;
      end
      bpa_pkg::OP_PUSH2: begin
        if (h != bpa_pkg::NIL) begin
          prev_we = 1'b1;
          prev_wa = h[FW-1:0];
          prev_wd = LW'(pf);
        end
      end
      bpa_pkg::OP_F_CHECK: begin
        info_ra     = pfn;
        status.fail = f_bad;
      end
      bpa_pkg::OP_F_STATE: begin
        status.fail = info_rd.st == bpa_pkg::FS_FREE;
      end
      bpa_pkg::OP_F_PAIR: begin
        info_ra     = pair_full[FW-1:0];
        status.stop = f_stop_pair;
      end
      bpa_pkg::OP_F_PCHK: begin
        link_ra     = pair;
        status.stop = pchk_stop;
      end
      bpa_pkg::OP_F_UNLINK: begin
        if (prev_rd != bpa_pkg::NIL) begin
          next_we = 1'b1;
          next_wa = prev_rd[FW-1:0];
          next_wd = next_rd;
        end
        if (next_rd != bpa_pkg::NIL) begin
          prev_we = 1'b1;
          prev_wa = next_rd[FW-1:0];
          prev_wd = prev_rd;
        end
        info_we = 1'b1;
        info_wa = (comb_rel == prel) ? pfn : pair;
        info_wd = '{order: bpa_pkg::MERGED_AWAY, st: bpa_pkg::FS_FREE};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    info_rd <= info_mem[info_ra];
    next_rd <= next_mem[link_ra];
    prev_rd <= prev_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= RW'(bpa_pkg::FRAMES);
      span_s       <= '0;
      span_e       <= '0;
      sweep_idx    <= '0;
      rsp_valid    <= 1'b0;
      for (int k = 0; k < bpa_pkg::HEADS; k++) list_head[k] <= bpa_pkg::NIL;
    end else begin
      if (cfg_we) begin
        case (bpa_pkg::reg_idx_t'(cfg_index))
          bpa_pkg::REG_REGION_START: region_start <= cfg_data;
          bpa_pkg::REG_REGION_END:   region_end   <= cfg_data;
          default: begin
          end
        endcase
      end
      // taken beat clears, unless a new one is loaded in the same cycle
      if (rsp_valid && rsp_ready && cmd.op != bpa_pkg::OP_OUT) rsp_valid <= 1'b0;
      case (cmd.op)
        bpa_pkg::OP_LATCH: begin
          span_s    <= s_calc;
          span_e    <= e_calc;
          pf        <= req.block_pfn;
          rel       <= FW'(SW'(req.block_pfn) - s_calc);
          want      <= want_c;
          alloc_bad <= bad_c;
          if (req.command == bpa_pkg::CMD_INIT) begin
            pfn       <= '0;
            cur       <= '0;
            sweep_idx <= '0;
            for (int k = 0; k < bpa_pkg::HEADS; k++) list_head[k] <= bpa_pkg::NIL;
          end else begin
            pfn <= req.block_pfn;
            cur <= req.block_order;
          end
        end
        bpa_pkg::OP_SWEEP: begin
          sweep_idx <= sweep_idx + FW'(1);
          if (sweep_last && span_s < SW'(span_e)) begin
            list_head[bpa_pkg::MAX_ORDER] <= LW'(span_e - RW'(bpa_pkg::BLK));
          end
        end
        bpa_pkg::OP_A_FIND: begin
          cur <= a_c;
          pfn <= a_head[FW-1:0];
        end
        bpa_pkg::OP_A_UNLINK: begin
          list_head[cur] <= next_rd;
        end
        bpa_pkg::OP_A_SPLIT: begin
          if (cur != want) begin
            cur <= cur - OW'(1);
            pf  <= pfn + (FW'(1) << (cur - OW'(1)));
          end
        end
        bpa_pkg::OP_PUSH1: begin
          h              <= list_head[cur];
          list_head[cur] <= LW'(pf);
        end
        bpa_pkg::OP_F_PAIR: begin
          pair <= pair_full[FW-1:0];
        end
        bpa_pkg::OP_F_UNLINK: begin
          if (prev_rd == bpa_pkg::NIL && list_head[cur] == LW'(pair)) begin
            list_head[cur] <= next_rd;
          end
          rel <= comb_rel;
          pfn <= merged_pfn[FW-1:0];
          pf  <= merged_pfn[FW-1:0];
          cur <= cur + OW'(1);
        end
        bpa_pkg::OP_OUT: begin
          rsp_valid <= 1'b1;
          rsp_ok    <= cmd.ok;
          rsp_pfn   <= cmd.ok ? pfn : '0;
          rsp_order <= cmd.ok ? cur : '0;
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/buddy_page_allocator.sv
// top level of the buddy page allocator
`default_nettype none
// Buddy page-frame allocator for up to 4096 frames in blocks of order 0 to 4.
// One request beat is taken at a time and gives exactly one response beat.
// Allocate and free step through a sequence of states, repeated for each
// split or merge step; the sequence follows from the single write port of
// each frame memory and the registered reads that the sequencer waits on.
// Initialize sweeps every frame, one per cycle. After reset the same sweep
// runs with an empty region, during which no request beat is taken;
// configuration writes go through at any time. The response register lets
// a new request start while the previous response beat still waits.
// Registers must be written only while idle; the block does not enforce it.
module buddy_page_allocator (
  input  logic                      clk,
  input  logic                      rst,
  bpa_req_if.sink                   req,
  bpa_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bpa_pkg::REG_W-1:0] cfg_data
);
  bpa_pkg::dp_cmd_t    cmd;
  bpa_pkg::dp_status_t status;
  bpa_pkg::req_t       req_pl;
  logic                rsp_valid, rsp_ok;
  logic [bpa_pkg::FRAME_W-1:0] rsp_pfn;
  logic [bpa_pkg::ORDER_W-1:0] rsp_order;

  // request payload as one struct for the datapath
  assign req_pl.command     = bpa_pkg::cmd_t'(req.command);
  assign req_pl.page_count  = req.page_count;
  assign req_pl.block_pfn   = req.block_pfn;
  assign req_pl.block_order = req.block_order;

  // sequencer: one state per memory step
  bpa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // frame memories, list heads and the response register
  bpa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req_pl),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .rsp_ok    (rsp_ok),
    .rsp_pfn   (rsp_pfn),
    .rsp_order (rsp_order)
  );

  // response beat
  assign rsp.valid        = rsp_valid;
  assign rsp.ok           = rsp_ok;
  assign rsp.result_pfn   = rsp_pfn;
  assign rsp.result_order = rsp_order;
endmodule
`default_nettype wire
